/* src/gspm_pkg.sv */
// Shared types, constants and coefficient tables for the gas concentration block.
package gspm_pkg;

    localparam int ADC_BITS       = 12;
    localparam int CHANNELS       = 3;
    localparam int MAX_OVERSAMPLE = 16;

    localparam logic [11:0] ADC_MAX       = 12'hFFF;
    localparam logic [4:0]  COUNT_RESET   = 5'd10;
    localparam logic [4:0]  COUNT_MAX     = 5'd16;
    localparam logic [29:0] SCALE_E9      = 30'd1000000000;
    localparam logic [31:0] SAT32         = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_BAD = 2'd1,
        STAT_ERR = 2'd2,
        STAT_SAT = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ACC,
        ST_AVG,
        ST_NUM,
        ST_DEN,
        ST_RAT,
        ST_NORM,
        ST_LOG,
        ST_YMUL,
        ST_YDIV,
        ST_XSTART,
        ST_XSQRT,
        ST_XMUL,
        ST_QMUL,
        ST_QDIV,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    function automatic logic [17:0] rom_rb(input logic [1:0] ch);
        logic [17:0] v;
        unique case (ch)
            2'd0:    v = 18'd189000;
            2'd1:    v = 18'd4630;
            default: v = 18'd18780;
        endcase
        return v;
    endfunction

    function automatic logic [17:0] rom_r0(input logic [1:0] ch);
        logic [17:0] v;
        unique case (ch)
            2'd0:    v = 18'd241000;
            2'd1:    v = 18'd7180;
            default: v = 18'd23020;
        endcase
        return v;
    endfunction

    // Magnitude of the exponent, scaled by 1e9
    function automatic logic [30:0] rom_a_mag(input logic [1:0] ch);
        logic [30:0] v;
        unique case (ch)
            2'd0:    v = 31'd1248392701;
            2'd1:    v = 31'd974912401;
            default: v = 31'd1845098040;
        endcase
        return v;
    endfunction

    function automatic logic rom_a_neg(input logic [1:0] ch);
        return (ch != 2'd1);
    endfunction

    function automatic logic [31:0] rom_expb(input logic [1:0] ch);
        logic [31:0] v;
        unique case (ch)
            2'd0:    v = 32'd3185771316;
            2'd1:    v = 32'd161707803;
            default: v = 32'd662508607;
        endcase
        return v;
    endfunction

endpackage

/* src/gspm_if.sv */
// Request channels: sample input and result output.
interface gspm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  channel;
    logic [11:0] sample;
    logic        adc_error;

    modport source (output valid, channel, sample, adc_error, input ready);
    modport sink   (input valid, channel, sample, adc_error, output ready);
endinterface

interface gspm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  channel_out;
    logic [31:0] resistance_ratio;
    logic [31:0] concentration;
    logic [1:0]  status;

    modport source (output valid, channel_out, resistance_ratio, concentration, status,
                    input ready);
    modport sink   (input valid, channel_out, resistance_ratio, concentration, status,
                    output ready);
endinterface

/* src/gspm_div.sv */
// Restoring divider, 64 by 32 bits, one quotient bit per cycle.
module gspm_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] dvd_reg, dvd_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [31:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;

    always_comb
    begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, dvd_reg[63]};
        rem_sub   = rem_sh - {1'b0, dsr_reg};
        if (start)
        begin
            dvd_next = dividend;
            dsr_next = divisor;
            rem_next = '0;
            cnt_next = 7'd64;
        end
        else if (cnt_reg != 7'd0)
        begin
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next = rem_sub[31:0];
                dvd_next = {dvd_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[31:0];
                dvd_next = {dvd_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

/* src/gspm_isqrt.sv */
// Integer square root of a 64-bit value, one result bit per cycle.
module gspm_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] v_reg, v_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg, bit_next;
    logic        done_reg, done_next;
    logic [63:0] trial;

    always_comb
    begin
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        done_next = 1'b0;
        trial     = r_reg + bit_reg;
        if (start)
        begin
            v_next   = value;
            r_next   = '0;
            bit_next = 64'h4000_0000_0000_0000;
        end
        else if (bit_reg != 64'd0)
        begin
            if (v_reg >= trial)
            begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == 64'd1)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            bit_reg  <= bit_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule

/* src/gas_sensor_ratio_to_ppm_top.sv */
// Top level: per-channel oversampling and divider-ratio to concentration conversion.
//
// Requests arrive on sample_ch (channel, sample, adc_error) and results leave on
// result_ch (channel_out, resistance_ratio, concentration, status). The count of
// samples per result is written through wr_en / wr_data at any time the block is idle.
// A sample that does not finish a burst goes through ST_ACC back to idle and gives no
// result. A bad channel or converter error gives one result through ST_ACC and ST_EMIT.
// A sample that finishes a burst runs the average, ratio and exponent divides on the
// shared serial divider (four of them), the normalize and log loops and the exp2 loop,
// which is 24 rounds of a serial square root and dominates. One request is worked on
// at a time; sample_ch.ready is high only while the block waits for the next request.
// Results sit in an output register, so a new request is taken while a result waits;
// a stalled receiver holds the block only once a second result is ready.
// Reset clears all burst sums and counts and sets the sample count to 10.
module gas_sensor_ratio_to_ppm_top (
    input  logic       clk,
    input  logic       rst_n,
    gspm_in_if.sink    sample_ch,
    gspm_out_if.source result_ch,
    input  logic       wr_en,
    input  logic [4:0] wr_data
);

    gspm_pkg::state_t state_reg, state_next;

    logic [4:0]  os_reg, os_next;
    logic [15:0] sum_reg [gspm_pkg::CHANNELS];
    logic [15:0] sum_next [gspm_pkg::CHANNELS];
    logic [4:0]  cnt_reg [gspm_pkg::CHANNELS];
    logic [4:0]  cnt_next [gspm_pkg::CHANNELS];

    logic [1:0]  ch_reg, ch_next;
    logic [11:0] smp_reg, smp_next;
    logic        err_reg, err_next;
    logic [11:0] avg_reg, avg_next;
    logic [29:0] num_reg, num_next;
    logic [31:0] ratio_reg, ratio_next;
    logic [31:0] norm_reg, norm_next;
    logic [4:0]  e_reg, e_next;
    logic [31:0] m_reg, m_next;
    logic [23:0] frac_reg, frac_next;
    logic [4:0]  it_reg, it_next;
    logic        yneg_reg, yneg_next;
    logic [7:0]  n_reg, n_next;
    logic [23:0] f_reg, f_next;
    logic [31:0] p_reg, p_next;
    logic [32:0] t_reg, t_next;
    logic [34:0] sh_reg, sh_next;
    logic [5:0]  shc_reg, shc_next;
    logic        left_reg, left_next;
    logic        ovf_reg, ovf_next;
    logic        sat_reg, sat_next;
    logic [31:0] conc_reg, conc_next;
    logic [1:0]  st_reg, st_next;

    logic        ov_reg, ov_next;
    logic [1:0]  och_reg, och_next;
    logic [31:0] oratio_reg, oratio_next;
    logic [31:0] oconc_reg, oconc_next;
    logic [1:0]  ost_reg, ost_next;

    logic        div_start;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [63:0] div_quot;
    logic        sq_start;
    logic [63:0] sq_value;
    logic        sq_done;
    logic [31:0] sq_root;

    gspm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    gspm_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_value),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_comb
    begin
        logic [4:0]  target;
        logic [15:0] acc_sum;
        logic [4:0]  acc_cnt;
        logic [63:0] sq;
        logic [32:0] mm;
        logic [29:0] l_val;
        logic [28:0] l_abs;
        logic [31:0] y;
        logic [8:0]  s;
        logic [8:0]  s_abs;
        logic [63:0] pt;

        state_next = state_reg;
        os_next    = os_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        ch_next    = ch_reg;
        smp_next   = smp_reg;
        err_next   = err_reg;
        avg_next   = avg_reg;
        num_next   = num_reg;
        ratio_next = ratio_reg;
        norm_next  = norm_reg;
        e_next     = e_reg;
        m_next     = m_reg;
        frac_next  = frac_reg;
        it_next    = it_reg;
        yneg_next  = yneg_reg;
        n_next     = n_reg;
        f_next     = f_reg;
        p_next     = p_reg;
        t_next     = t_reg;
        sh_next    = sh_reg;
        shc_next   = shc_reg;
        left_next  = left_reg;
        ovf_next   = ovf_reg;
        sat_next   = sat_reg;
        conc_next  = conc_reg;
        st_next    = st_reg;

        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        sq_start     = 1'b0;
        sq_value     = {t_reg, 31'd0};

        if (os_reg == 5'd0)
        begin
            target = 5'd1;
        end
        else if (os_reg > gspm_pkg::COUNT_MAX)
        begin
            target = gspm_pkg::COUNT_MAX;
        end
        else
        begin
            target = os_reg;
        end

        acc_sum = '0;
        acc_cnt = '0;
        sq      = {32'd0, m_reg} * {32'd0, m_reg};
        mm      = sq[63:31];
        l_val   = {1'b0, e_reg, 24'd0} - {30'd16 << 24} + {6'd0, frac_reg};
        l_abs   = l_val[29] ? 29'(-l_val) : l_val[28:0];
        y       = yneg_reg ? -div_quot[31:0] : div_quot[31:0];
        s       = {n_reg[7], n_reg} - 9'd15;
        s_abs   = s[8] ? -s : s;
        pt      = {32'd0, p_reg} * {32'd0, t_reg[31:0]};

        if (wr_en)
        begin
            os_next = wr_data;
        end

        unique case (state_reg)
            gspm_pkg::ST_IDLE:
            begin
                if (sample_ch.valid)
                begin
                    ch_next    = sample_ch.channel;
                    smp_next   = sample_ch.sample;
                    err_next   = sample_ch.adc_error;
                    state_next = gspm_pkg::ST_ACC;
                end
            end
            gspm_pkg::ST_ACC:
            begin
                ratio_next = '0;
                conc_next  = '0;
                sat_next   = 1'b0;
                if (ch_reg >= 2'(gspm_pkg::CHANNELS))
                begin
                    st_next    = gspm_pkg::STAT_BAD;
                    state_next = gspm_pkg::ST_EMIT;
                end
                else if (err_reg)
                begin
                    sum_next[ch_reg] = '0;
                    cnt_next[ch_reg] = '0;
                    st_next          = gspm_pkg::STAT_ERR;
                    state_next       = gspm_pkg::ST_EMIT;
                end
                else
                begin
                    acc_sum = sum_reg[ch_reg] + {4'd0, smp_reg};
                    acc_cnt = cnt_reg[ch_reg] + 5'd1;
                    if (acc_cnt < target)
                    begin
                        sum_next[ch_reg] = acc_sum;
                        cnt_next[ch_reg] = acc_cnt;
                        state_next       = gspm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        sum_next[ch_reg] = '0;
                        cnt_next[ch_reg] = '0;
                        div_start        = 1'b1;
                        div_dividend     = {48'd0, acc_sum};
                        div_divisor      = {27'd0, acc_cnt};
                        state_next       = gspm_pkg::ST_AVG;
                    end
                end
            end
            gspm_pkg::ST_AVG:
            begin
                if (div_done)
                begin
                    avg_next = div_quot[11:0];
                    if (div_quot[11:0] == gspm_pkg::ADC_MAX)
                    begin
                        ratio_next = gspm_pkg::SAT32;
                        conc_next  = gspm_pkg::rom_a_neg(ch_reg) ? 32'd0 : gspm_pkg::SAT32;
                        st_next    = gspm_pkg::STAT_SAT;
                        state_next = gspm_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = gspm_pkg::ST_NUM;
                    end
                end
            end
            gspm_pkg::ST_NUM:
            begin
                num_next   = gspm_pkg::rom_rb(ch_reg) * avg_reg;
                state_next = gspm_pkg::ST_DEN;
            end
            gspm_pkg::ST_DEN:
            begin
                div_start    = 1'b1;
                div_dividend = {18'd0, num_reg, 16'd0};
                div_divisor  = {2'd0, 30'((gspm_pkg::ADC_MAX - avg_reg)
                                          * gspm_pkg::rom_r0(ch_reg))};
                state_next   = gspm_pkg::ST_RAT;
            end
            gspm_pkg::ST_RAT:
            begin
                if (div_done)
                begin
                    if (div_quot == 64'd0)
                    begin
                        ratio_next = '0;
                        conc_next  = gspm_pkg::rom_a_neg(ch_reg) ? gspm_pkg::SAT32 : 32'd0;
                        st_next    = gspm_pkg::STAT_SAT;
                        state_next = gspm_pkg::ST_EMIT;
                    end
                    else
                    begin
                        if (div_quot[63:32] != 32'd0)
                        begin
                            ratio_next = gspm_pkg::SAT32;
                            norm_next  = gspm_pkg::SAT32;
                            sat_next   = 1'b1;
                        end
                        else
                        begin
                            ratio_next = div_quot[31:0];
                            norm_next  = div_quot[31:0];
                        end
                        e_next     = 5'd31;
                        state_next = gspm_pkg::ST_NORM;
                    end
                end
            end
            gspm_pkg::ST_NORM:
            begin
                // advance until the leading one reaches the top bit
                if (norm_reg[31])
                begin
                    m_next     = norm_reg;
                    frac_next  = '0;
                    it_next    = '0;
                    state_next = gspm_pkg::ST_LOG;
                end
                else
                begin
                    norm_next = {norm_reg[30:0], 1'b0};
                    e_next    = e_reg - 5'd1;
                end
            end
            gspm_pkg::ST_LOG:
            begin
                if (mm[32])
                begin
                    m_next    = mm[32:1];
                    frac_next = {frac_reg[22:0], 1'b1};
                end
                else
                begin
                    m_next    = mm[31:0];
                    frac_next = {frac_reg[22:0], 1'b0};
                end
                it_next = it_reg + 5'd1;
                if (it_reg == 5'd23)
                begin
                    state_next = gspm_pkg::ST_YMUL;
                end
            end
            gspm_pkg::ST_YMUL:
            begin
                yneg_next    = l_val[29] ^ gspm_pkg::rom_a_neg(ch_reg);
                div_start    = 1'b1;
                div_dividend = {4'd0, 60'(gspm_pkg::rom_a_mag(ch_reg) * l_abs)};
                div_divisor  = {2'd0, gspm_pkg::SCALE_E9};
                state_next   = gspm_pkg::ST_YDIV;
            end
            gspm_pkg::ST_YDIV:
            begin
                if (div_done)
                begin
                    n_next     = y[31:24];
                    f_next     = y[23:0];
                    p_next     = 32'h8000_0000;
                    t_next     = 33'h1_0000_0000;
                    it_next    = '0;
                    state_next = gspm_pkg::ST_XSTART;
                end
            end
            gspm_pkg::ST_XSTART:
            begin
                sq_start   = 1'b1;
                state_next = gspm_pkg::ST_XSQRT;
            end
            gspm_pkg::ST_XSQRT:
            begin
                if (sq_done)
                begin
                    t_next     = {1'b0, sq_root};
                    state_next = gspm_pkg::ST_XMUL;
                end
            end
            gspm_pkg::ST_XMUL:
            begin
                if (f_reg[23])
                begin
                    p_next = pt[62:31];
                end
                f_next  = {f_reg[22:0], 1'b0};
                it_next = it_reg + 5'd1;
                if (it_reg == 5'd23)
                begin
                    state_next = gspm_pkg::ST_QMUL;
                end
                else
                begin
                    state_next = gspm_pkg::ST_XSTART;
                end
            end
            gspm_pkg::ST_QMUL:
            begin
                div_start    = 1'b1;
                div_dividend = {32'd0, p_reg} * {32'd0, gspm_pkg::rom_expb(ch_reg)};
                div_divisor  = {2'd0, gspm_pkg::SCALE_E9};
                state_next   = gspm_pkg::ST_QDIV;
            end
            gspm_pkg::ST_QDIV:
            begin
                if (div_done)
                begin
                    sh_next   = div_quot[34:0];
                    left_next = !s[8];
                    shc_next  = (s_abs > 9'd63) ? 6'd63 : s_abs[5:0];
                    ovf_next  = 1'b0;
                    state_next = gspm_pkg::ST_SHIFT;
                end
            end
            gspm_pkg::ST_SHIFT:
            begin
                if (shc_reg == 6'd0)
                begin
                    if (left_reg && (ovf_reg || sh_reg[34:32] != 3'd0))
                    begin
                        conc_next = gspm_pkg::SAT32;
                        st_next   = gspm_pkg::STAT_SAT;
                    end
                    else
                    begin
                        conc_next = sh_reg[31:0];
                        st_next   = sat_reg ? gspm_pkg::STAT_SAT : gspm_pkg::STAT_OK;
                    end
                    state_next = gspm_pkg::ST_EMIT;
                end
                else if (left_reg)
                begin
                    ovf_next = ovf_reg | sh_reg[34];
                    sh_next  = {sh_reg[33:0], 1'b0};
                    shc_next = shc_reg - 6'd1;
                end
                else
                begin
                    sh_next  = {1'b0, sh_reg[34:1]};
                    shc_next = shc_reg - 6'd1;
                end
            end
            gspm_pkg::ST_EMIT:
            begin
                if (!ov_reg || result_ch.ready)
                begin
                    state_next = gspm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gspm_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register: load on a finished result, drop once taken
    always_comb
    begin
        ov_next     = ov_reg;
        och_next    = och_reg;
        oratio_next = oratio_reg;
        oconc_next  = oconc_reg;
        ost_next    = ost_reg;
        if (ov_reg && result_ch.ready)
        begin
            ov_next = 1'b0;
        end
        if (state_reg == gspm_pkg::ST_EMIT && (!ov_reg || result_ch.ready))
        begin
            ov_next     = 1'b1;
            och_next    = ch_reg;
            oratio_next = ratio_reg;
            oconc_next  = conc_reg;
            ost_next    = st_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gspm_pkg::ST_IDLE;
            os_reg    <= gspm_pkg::COUNT_RESET;
            ov_reg    <= 1'b0;
            for (int i = 0; i < gspm_pkg::CHANNELS; i++)
            begin
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            os_reg    <= os_next;
            ov_reg    <= ov_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg     <= ch_next;
        smp_reg    <= smp_next;
        err_reg    <= err_next;
        avg_reg    <= avg_next;
        num_reg    <= num_next;
        ratio_reg  <= ratio_next;
        norm_reg   <= norm_next;
        e_reg      <= e_next;
        m_reg      <= m_next;
        frac_reg   <= frac_next;
        it_reg     <= it_next;
        yneg_reg   <= yneg_next;
        n_reg      <= n_next;
        f_reg      <= f_next;
        p_reg      <= p_next;
        t_reg      <= t_next;
        sh_reg     <= sh_next;
        shc_reg    <= shc_next;
        left_reg   <= left_next;
        ovf_reg    <= ovf_next;
        sat_reg    <= sat_next;
        conc_reg   <= conc_next;
        st_reg     <= st_next;
        och_reg    <= och_next;
        oratio_reg <= oratio_next;
        oconc_reg  <= oconc_next;
        ost_reg    <= ost_next;
    end

    assign sample_ch.ready            = (state_reg == gspm_pkg::ST_IDLE);
    assign result_ch.valid            = ov_reg;
    assign result_ch.channel_out      = och_reg;
    assign result_ch.resistance_ratio = oratio_reg;
    assign result_ch.concentration    = oconc_reg;
    assign result_ch.status           = ost_reg;

endmodule

/* tb/tb_gas_sensor_ratio_to_ppm_top.sv */
// Testbench for the gas sensor ratio-to-concentration block: random and directed requests
// checked against a built-in fixed-point predictor.
`timescale 1ns / 1ps

module tb_gas_sensor_ratio_to_ppm_top;

    typedef struct packed {
        logic [1:0]  channel;
        logic [11:0] sample;
        logic        adc_error;
    } sample_req_t;

    typedef struct packed {
        logic [1:0]          channel_out;
        logic [31:0]         resistance_ratio;
        logic [31:0]         concentration;
        gspm_pkg::status_t   status;
    } ppm_result_t;

    localparam longint unsigned SAT64 = 64'hFFFF_FFFF;
    localparam longint          E9    = 64'd1000000000;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [4:0] wr_data;

    gspm_in_if  sample_ch ();
    gspm_out_if result_ch ();

    gas_sensor_ratio_to_ppm_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .wr_en     (wr_en),
        .wr_data   (wr_data)
    );

    sample_req_t pending_reqs[$];
    ppm_result_t expected_ppm[$];
    logic [15:0] burst_sum[3];
    logic [4:0]  burst_cnt[3];
    logic [4:0]  count_cfg;
    int          queued_n;
    int          accepted_n;
    int          mismatches;
    int          gap_left;
    int          stall_left;
    int          hold_left;
    bit          req_taken;
    bit          no_idle;
    bit          start_hold;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // log2(x / 65536) in signed Q.24
    function automatic longint log2_ratio(input logic [31:0] x);
        int              e;
        longint unsigned m;
        longint unsigned frac;
        e = 31;
        frac = 0;
        while (e > 0 && x[e] == 1'b0)
            e--;
        m = longint'(x) << (31 - e);
        for (int i = 0; i < 24; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32))
            begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return longint'(e - 16) * (64'sd1 << 24) + longint'(frac);
    endfunction

    // 2^(f / 2^24) in Q1.31
    function automatic longint unsigned exp2_fraction(input longint unsigned f);
        longint unsigned p;
        longint unsigned t;
        p = 64'd1 << 31;
        t = 64'd1 << 32;
        for (int i = 1; i <= 24; i++)
        begin
            t = int_sqrt(t << 31);
            if (f[24 - i])
                p = (p * t) >> 31;
        end
        return p;
    endfunction

    // Advance burst state for one accepted request; return 1 if a result is due
    function automatic bit predict_ppm(input sample_req_t rq, output ppm_result_t rs);
        logic [4:0]      target;
        logic [11:0]     avg;
        longint unsigned num;
        longint unsigned den;
        longint unsigned ratio;
        longint unsigned conc;
        longint unsigned p;
        longint unsigned q;
        longint          a;
        longint          l;
        longint          y;
        longint          n;
        longint          s;
        bit              sat;
        int              c;
        c = rq.channel;
        sat = 0;
        rs = '0;
        rs.channel_out = rq.channel;
        if (c >= gspm_pkg::CHANNELS)
        begin
            rs.status = gspm_pkg::STAT_BAD;
            return 1;
        end
        if (rq.adc_error)
        begin
            burst_sum[c] = 0;
            burst_cnt[c] = 0;
            rs.status = gspm_pkg::STAT_ERR;
            return 1;
        end
        burst_sum[c] = burst_sum[c] + rq.sample;
        burst_cnt[c] = burst_cnt[c] + 1;
        target = count_cfg;
        if (target < 1)
            target = 1;
        if (target > gspm_pkg::COUNT_MAX)
            target = gspm_pkg::COUNT_MAX;
        if (burst_cnt[c] < target)
            return 0;
        avg = burst_sum[c] / burst_cnt[c];
        burst_sum[c] = 0;
        burst_cnt[c] = 0;
        a = gspm_pkg::rom_a_neg(rq.channel) ? -longint'(gspm_pkg::rom_a_mag(rq.channel))
                                            : longint'(gspm_pkg::rom_a_mag(rq.channel));
        if (avg == gspm_pkg::ADC_MAX)
        begin
            rs.resistance_ratio = gspm_pkg::SAT32;
            rs.concentration = (a > 0) ? gspm_pkg::SAT32 : 32'd0;
            rs.status = gspm_pkg::STAT_SAT;
            return 1;
        end
        num = longint'(gspm_pkg::rom_rb(rq.channel)) * longint'(avg) * 65536;
        den = longint'(gspm_pkg::ADC_MAX - avg) * longint'(gspm_pkg::rom_r0(rq.channel));
        ratio = num / den;
        if (ratio > SAT64)
        begin
            ratio = SAT64;
            sat = 1;
        end
        if (ratio == 0)
        begin
            rs.concentration = (a < 0) ? gspm_pkg::SAT32 : 32'd0;
            rs.status = gspm_pkg::STAT_SAT;
            return 1;
        end
        l = log2_ratio(ratio[31:0]);
        y = (a * l) / E9;
        if (y >= 0)
            n = y / (64'sd1 << 24);
        else
            n = -((-y + (64'sd1 << 24) - 1) / (64'sd1 << 24));
        p = exp2_fraction(y - n * (64'sd1 << 24));
        q = (p * longint'(gspm_pkg::rom_expb(rq.channel))) / E9;
        s = n - 15;
        if (s >= 0)
        begin
            if (s > 31 || q > (SAT64 >> s))
            begin
                conc = SAT64;
                sat = 1;
            end
            else
                conc = q << s;
        end
        else
            conc = (-s >= 64) ? 0 : (q >> (-s));
        rs.resistance_ratio = ratio[31:0];
        rs.concentration = conc[31:0];
        rs.status = sat ? gspm_pkg::STAT_SAT : gspm_pkg::STAT_OK;
        return 1;
    endfunction

    // Driver: note acceptance at the rising edge, change inputs at the falling edge
    always @(posedge clk)
    begin
        ppm_result_t rs;
        if (rst_n && sample_ch.valid && sample_ch.ready)
        begin
            if (predict_ppm('{sample_ch.channel, sample_ch.sample, sample_ch.adc_error}, rs))
                expected_ppm.push_back(rs);
            accepted_n++;
            req_taken = 1;
        end
    end

    always @(negedge clk)
    begin
        sample_req_t rq;
        if (rst_n && (!sample_ch.valid || req_taken))
        begin
            req_taken = 0;
            if (gap_left > 0)
            begin
                gap_left--;
                sample_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                rq = pending_reqs.pop_front();
                sample_ch.valid     <= 1'b1;
                sample_ch.channel   <= rq.channel;
                sample_ch.sample    <= rq.sample;
                sample_ch.adc_error <= rq.adc_error;
                if (!no_idle && $urandom_range(0, 4) == 0)
                    gap_left = $urandom_range(1, 3);
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    // Receiver ready: one long hold on request, otherwise short random stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start_hold)
            begin
                start_hold = 0;
                hold_left = 4000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 4) == 0)
                    stall_left = $urandom_range(1, 3);
            end
        end
    end

    task automatic report_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0h, actual %0h", what, want, got);
    endtask

    // Monitor
    always @(posedge clk)
    begin
        ppm_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_ppm.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: channel %0d status %0d",
                             result_ch.channel_out, result_ch.status);
            end
            else
            begin
                want = expected_ppm.pop_front();
                if (result_ch.channel_out !== want.channel_out)
                    report_field("channel_out", want.channel_out, result_ch.channel_out);
                if (result_ch.resistance_ratio !== want.resistance_ratio)
                    report_field("resistance_ratio", want.resistance_ratio,
                                 result_ch.resistance_ratio);
                if (result_ch.concentration !== want.concentration)
                    report_field("concentration", want.concentration,
                                 result_ch.concentration);
                if (result_ch.status !== want.status)
                    report_field("status", want.status, result_ch.status);
            end
        end
    end

    task automatic push_req(input int ch, input int smp, input bit err);
        pending_reqs.push_back('{ch[1:0], smp[11:0], err});
        queued_n++;
    endtask

    // Hold until every request is taken and every result has arrived
    task automatic wait_idle();
        wait (accepted_n == queued_n && expected_ppm.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_count(input logic [4:0] v);
        wait_idle();
        @(negedge clk);
        wr_en <= 1'b1;
        wr_data <= v;
        @(negedge clk);
        wr_en <= 1'b0;
        count_cfg = v;
    endtask

    task automatic push_random(input int num);
        int ch;
        int smp;
        int mode;
        for (int i = 0; i < num; i++)
        begin
            ch = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2);
            mode = $urandom_range(0, 9);
            if (mode == 0)
                smp = 4095;
            else if (mode == 1)
                smp = $urandom_range(0, 3);
            else if (mode == 2)
                smp = $urandom_range(4000, 4095);
            else
                smp = $urandom_range(0, 4095);
            push_req(ch, smp, $urandom_range(0, 24) == 0);
        end
    endtask

    initial
    begin
        logic [4:0] counts[10] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd4, 5'd10, 5'd3,
                                   5'd17, 5'd1};
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.channel = '0;
        sample_ch.sample = '0;
        sample_ch.adc_error = 1'b0;
        result_ch.ready = 1'b0;
        queued_n = 0;
        accepted_n = 0;
        mismatches = 0;
        gap_left = 0;
        stall_left = 0;
        hold_left = 0;
        req_taken = 0;
        no_idle = 0;
        start_hold = 0;
        count_cfg = gspm_pkg::COUNT_RESET;
        for (int i = 0; i < 3; i++)
        begin
            burst_sum[i] = '0;
            burst_cnt[i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Partial burst at the reset count, then lower the count mid-burst
        push_req(0, 1000, 0);
        push_req(0, 1200, 0);
        push_req(0, 800, 0);
        write_count(5'd1);
        push_req(0, 500, 0);
        push_req(0, 4095, 0);
        push_req(1, 4095, 0);
        push_req(2, 4095, 0);
        push_req(0, 0, 0);
        push_req(1, 0, 0);
        push_req(2, 0, 0);
        push_req(0, 4094, 0);
        push_req(1, 4094, 0);
        push_req(2, 4094, 0);
        push_req(0, 1, 0);
        push_req(1, 2048, 0);
        push_req(2, 2730, 0);
        push_req(3, 4095, 0);
        push_req(3, 0, 1);
        push_req(0, 1234, 1);
        push_req(1, 2748, 1);
        push_req(2, 3000, 0);

        // Fill the block while the receiver holds off
        wait_idle();
        start_hold = 1;
        push_random(30);

        for (int ph = 0; ph < 10; ph++)
        begin
            write_count(counts[ph]);
            if (ph == 9)
                no_idle = 1;
            push_random(50);
        end

        wait (accepted_n == queued_n && expected_ppm.size() == 0);
        repeat (1500) @(posedge clk);
        if (mismatches == 0 && expected_ppm.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
